@@ src/b2da_pkg.sv @@
`default_nettype none

package b2da_pkg;

	localparam int unsigned BinWidth  = 32;
	localparam int unsigned NumDigits = 10;
	localparam int unsigned BcdWidth  = 4 * NumDigits;
	localparam int unsigned CntWidth  = $clog2(BinWidth);
	localparam int unsigned IdxWidth  = $clog2(NumDigits);

	localparam logic [1:0] AsciiZeroHi = 2'b11;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_COUNT,
		ST_EMIT
	} b2da_state_t;

	typedef logic [BcdWidth-1:0] b2da_bcd_t;

endpackage

`default_nettype wire

@@ src/b2da_dabble.sv @@
`default_nettype none

module b2da_dabble
	import b2da_pkg::*;
(
	input  wire b2da_bcd_t bcd_in,
	input  wire            bit_in,
	output b2da_bcd_t      bcd_out
);

	b2da_bcd_t adj;

	always_comb begin
		for (int i = 0; i < NumDigits; i++) begin
			if (bcd_in[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_in[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_in[4*i +: 4];
			end
		end
	end

	assign bcd_out = {adj[BcdWidth-2:0], bit_in};

endmodule

`default_nettype wire

@@ src/binary_to_decimal_ascii.sv @@
// The first digit beat follows the conversion pass and the count state, then one digit per cycle.
// Each value yields 1 to 10 digits; a new value is taken only when idle, after the last digit.
// The conversion makes one shift-and-adjust pass of the shared BCD unit per input bit.
// Digits leave as single-cycle strobes; the receiver cannot stall them.
// Reset (arst_n low, asynchronous) returns the sequencer to idle with busy low.
`default_nettype none

module binary_to_decimal_ascii
	import b2da_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire [BinWidth-1:0]   value,
	output logic                 strobe,
	output logic [5:0]           digit_char,
	output logic                 last
);

	b2da_state_t         state_q, state_d;
	logic [BinWidth-1:0] bin_q;
	b2da_bcd_t           bcd_q;
	b2da_bcd_t           bcd_next;
	logic [CntWidth-1:0] cnt_q;
	logic [IdxWidth-1:0] idx_q;
	logic [IdxWidth-1:0] top_idx;
	logic [3:0]          cur_digit;

	b2da_dabble u_dabble (
		.bcd_in  (bcd_q),
		.bit_in  (bin_q[BinWidth-1]),
		.bcd_out (bcd_next)
	);

	always_comb begin
		top_idx = '0;
		for (int i = 0; i < NumDigits; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				top_idx = IdxWidth'(i);
			end
		end
	end

	assign cur_digit = bcd_q[4*idx_q +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (cnt_q == CntWidth'(BinWidth - 1)) state_d = ST_COUNT;
			end
			ST_COUNT: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (idx_q == '0) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				bin_q <= value;
				bcd_q <= '0;
				cnt_q <= '0;
			end
			ST_CONV: begin
				bcd_q <= bcd_next;
				bin_q <= {bin_q[BinWidth-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_COUNT: begin
				idx_q <= top_idx;
			end
			ST_EMIT: begin
				idx_q <= idx_q - 1'b1;
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	assign busy       = (state_q != ST_IDLE);
	assign strobe     = (state_q == ST_EMIT);
	assign digit_char = {AsciiZeroHi, cur_digit};
	assign last       = strobe && (idx_q == '0);

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("digit beat outside a busy period");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		last |=> !busy && !strobe)
		else $error("run continues after last digit");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy && !strobe)
		else $error("accepted value did not start conversion");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (digit_char[3:0] <= 4'd9))
		else $error("digit out of decimal range");

	a_no_early_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |=> !strobe)
		else $error("digit emitted before conversion finished");

endmodule

`default_nettype wire

@@ verif/binary_to_decimal_ascii_test.sv @@
`default_nettype none

module binary_to_decimal_ascii_test;
	import b2da_pkg::*;

	typedef struct packed {
		logic [5:0] digit_char;
		logic       last;
	} digit_beat_t;

	typedef struct {
		logic [BinWidth-1:0] value;
		string               text;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [BinWidth-1:0] value = '0;
	logic                busy;
	logic                strobe;
	logic [5:0]          digit_char;
	logic                last;

	digit_beat_t pending_digits[$];
	int unsigned mismatch_count = 0;
	int unsigned idle_pct = 0;

	stim_row_t directed_rows [20] = '{
		'{32'd0,          "0"},
		'{32'd1,          "1"},
		'{32'd9,          "9"},
		'{32'd10,         "10"},
		'{32'd100,        "100"},
		'{32'd4294967295, "4294967295"},
		'{32'd1000000000, "1000000000"},
		'{32'd4294967290, "4294967290"},
		'{32'd4000000000, "4000000000"},
		'{32'd999999999,  "999999999"},
		'{32'd1234567890, "1234567890"},
		'{32'd2147483648, ""},
		'{32'd2147483647, ""},
		'{32'h5555_5555,  ""},
		'{32'hAAAA_AAAA,  ""},
		'{32'h8000_0001,  ""},
		'{32'd99,         ""},
		'{32'd3999999999, ""},
		'{32'd65536,      ""},
		'{32'd1073741824, ""}
	};

	binary_to_decimal_ascii dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.strobe     (strobe),
		.digit_char (digit_char),
		.last       (last)
	);

	always #6 clk = ~clk;

	function automatic void queue_decimal_digits(logic [BinWidth-1:0] v);
		logic [3:0]          digits [10];
		logic [BinWidth-1:0] rest;
		int                  n;
		digit_beat_t         beat;
		rest = v;
		n = 0;
		do begin
			digits[n] = 4'(rest % 10);
			rest = rest / 10;
			n++;
		end while (rest != 0 && n < 10);
		for (int k = n - 1; k >= 0; k--) begin
			beat.digit_char = 6'(8'd48 + 8'(digits[k]));
			beat.last = (k == 0);
			pending_digits.push_back(beat);
		end
	endfunction

	function automatic void queue_text_digits(string text);
		digit_beat_t beat;
		byte         ch;
		for (int i = 0; i < text.len(); i++) begin
			ch = text[i];
			beat.digit_char = ch[5:0];
			beat.last = (i == text.len() - 1);
			pending_digits.push_back(beat);
		end
	endfunction

	task automatic offer_value(logic [BinWidth-1:0] v);
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
	endtask

	task automatic sender_gap();
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 48)) @(posedge clk);
		end
	endtask

	task automatic drain_digits();
		start <= 1'b0;
		while (pending_digits.size() != 0) @(posedge clk);
	endtask

	function automatic logic [BinWidth-1:0] random_value();
		longint unsigned lo, hi;
		int unsigned     ndig;
		case ($urandom_range(3))
			0: return $urandom;
			1: begin
				ndig = $urandom_range(1, 10);
				lo = (ndig == 1) ? 0 : 64'd1;
				hi = 64'd1;
				for (int i = 0; i < ndig; i++) hi = hi * 10;
				for (int i = 1; i < ndig; i++) lo = lo * 10;
				hi = hi - 1;
				if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
				return $urandom_range(32'(hi), 32'(lo));
			end
			2: return $urandom_range(0, 999);
			default: return $urandom_range(0, 42949) * 100000;
		endcase
	endfunction

	task automatic random_phase(int unsigned pct, int unsigned count);
		logic [BinWidth-1:0] v;
		idle_pct = pct;
		for (int i = 0; i < count; i++) begin
			v = random_value();
			offer_value(v);
			queue_decimal_digits(v);
			sender_gap();
		end
		drain_digits();
	endtask

	always @(posedge clk) begin
		digit_beat_t want;
		if (arst_n && strobe) begin
			if (pending_digits.size() == 0) begin
				$error("digit beat with none expected: digit_char %0d last %0b",
					digit_char, last);
				mismatch_count++;
			end else begin
				want = pending_digits.pop_front();
				if (digit_char !== want.digit_char) begin
					$error("digit_char: expected %0d, actual %0d",
						want.digit_char, digit_char);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 25;
		foreach (directed_rows[i]) begin
			offer_value(directed_rows[i].value);
			if (directed_rows[i].text.len() != 0)
				queue_text_digits(directed_rows[i].text);
			else
				queue_decimal_digits(directed_rows[i].value);
			sender_gap();
		end
		drain_digits();

		random_phase(25, 147);
		random_phase(54, 147);
		random_phase(0, 146);

		repeat (60) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#6000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
src/b2da_pkg.sv
src/b2da_dabble.sv
src/binary_to_decimal_ascii.sv
verif/binary_to_decimal_ascii_test.sv
